// ===== design/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB to HSL and chromaticity pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHAN_W  = 8;
    localparam int IN_W    = 3 * CHAN_W;
    localparam int OUT_W   = 48;
    localparam int NUM_W   = 16;
    localparam int DEN_W   = 10;
    localparam int QUO_W   = 9;

    // Hue sector offsets, 40 steps per 60-degree sector.
    localparam logic [7:0] HUE_BASE_RED   = 8'd0;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd80;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd160;
    localparam logic [7:0] HUE_BASE_WRAP  = 8'd240;

    // 240/510 reduces to 8/17; 8*sum/17 is taken as sum times ceil(2^16*8/17)
    // shifted right by 16, which is exact for every sum up to 510.
    localparam logic [14:0] LIT_RECIP = 15'd30841;

    // Per-pixel flags that ride alongside the dividers.
    typedef struct packed {
        logic [7:0] lit;
        logic [7:0] base;
        logic       neg;
        logic       gray;
        logic       black;
    } rhc_side_t;

    // Divider operands produced by the front stage.
    typedef struct packed {
        logic [NUM_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
        logic [NUM_W-1:0] sat_num;
        logic [DEN_W-1:0] sat_den;
        logic [NUM_W-1:0] rc_num;
        logic [NUM_W-1:0] gc_num;
        logic [DEN_W-1:0] tot_den;
    } rhc_ops_t;

endpackage

// ===== design/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front
// First pipeline stage: channel extremes, sector choice and divider operands.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    output logic                   valid_reg,
    output rhc_pkg::rhc_side_t     side_reg,
    output rhc_pkg::rhc_ops_t      ops_reg
);
    import rhc_pkg::*;

    logic [7:0]       mx, mn, dlt, p, q, n;
    logic [8:0]       sum;
    logic [9:0]       tot;
    logic [23:0]      lit_prod;
    logic             gray, black, neg;
    logic [7:0]       base;
    rhc_side_t        side_next;
    rhc_ops_t         ops_next;

    always_comb begin
        // Largest and smallest channel.
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        dlt   = mx - mn;
        sum   = {1'b0, mx} + {1'b0, mn};
        tot   = {2'b00, red} + {2'b00, green} + {2'b00, blue};
        gray  = (mx == mn);
        black = (tot == 10'd0);

        // Lightness is a constant division, done by reciprocal multiply.
        lit_prod = 24'(sum) * 24'(LIT_RECIP);

        // Sector selection, red tested first, then green.
        if (red == mx) begin
            p    = green;
            q    = blue;
            base = HUE_BASE_RED;
        end else if (green == mx) begin
            p    = blue;
            q    = red;
            base = HUE_BASE_GREEN;
        end else begin
            p    = red;
            q    = green;
            base = HUE_BASE_BLUE;
        end
        neg = (p < q);
        n   = neg ? (q - p) : (p - q);
        if (neg && (red == mx)) base = HUE_BASE_WRAP;

        side_next.lit   = lit_prod[23:16];
        side_next.base  = base;
        side_next.neg   = neg;
        side_next.gray  = gray;
        side_next.black = black;

        // A negative offset rounds up, so the numerator gets d-1 added.
        ops_next.hue_num = NUM_W'(n) * NUM_W'(40);
        if (neg && !gray) ops_next.hue_num = ops_next.hue_num + NUM_W'(dlt) - NUM_W'(1);
        ops_next.hue_den = gray ? DEN_W'(1) : DEN_W'(dlt);

        ops_next.sat_num = NUM_W'(dlt) * NUM_W'(240);
        if (gray)
            ops_next.sat_den = DEN_W'(1);
        else if (sum < 9'd255)
            ops_next.sat_den = DEN_W'(sum);
        else
            ops_next.sat_den = DEN_W'(10'd510 - DEN_W'(sum));

        ops_next.rc_num  = {red, 8'h00};
        ops_next.gc_num  = {green, 8'h00};
        ops_next.tot_den = black ? DEN_W'(1) : tot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            ops_reg  <= ops_next;
        end
    end

endmodule

// ===== design/rhc_div.sv =====
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rhc_div #(
    parameter int NUM_W = rhc_pkg::NUM_W,
    parameter int DEN_W = rhc_pkg::DEN_W,
    parameter int QUO_W = rhc_pkg::QUO_W
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);
    import rhc_pkg::*;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] lo_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    // The quotient must fit in QUO_W bits, so the upper numerator bits start
    // as a remainder below the divisor; the low bits shift in one per stage.
    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_cur, den_cur;
        logic [QUO_W-1:0] lo_cur;
        logic [DEN_W:0]   trial;
        logic             qbit;

        if (k == 0) begin : g_first
            assign rem_cur = DEN_W'(num >> QUO_W);
            assign lo_cur  = num[QUO_W-1:0];
            assign den_cur = den;
        end else begin : g_next
            assign rem_cur = rem_reg[k-1];
            assign lo_cur  = lo_reg[k-1];
            assign den_cur = den_reg[k-1];
        end

        assign trial = {rem_cur, lo_cur[QUO_W-1]};
        assign qbit  = (trial >= {1'b0, den_cur});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= qbit ? DEN_W'(trial - {1'b0, den_cur}) : DEN_W'(trial);
                lo_reg[k]  <= {lo_cur[QUO_W-2:0], qbit};
                den_reg[k] <= den_cur;
            end
        end
    end

    assign quo = lo_reg[QUO_W-1];

endmodule

// ===== design/rgb_to_hsl_and_chromaticity_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_and_chromaticity_core
// Converts one RGB pixel per beat into HSL (0..240 scale) and rg chromaticity.
// ----------------------------------------------------------------------------
// Stages: one operand stage, nine divider stages, one output stage. Throughput:
// one pixel per cycle while the output is not stalled; the bit-serial divider
// pipelines set the depth. The whole pipeline holds while the output beat
// waits. Reset clears all valid bits; data is not reset.
module rgb_to_hsl_and_chromaticity_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rhc_pkg::IN_W-1:0]   s_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rhc_pkg::OUT_W-1:0]  m_tdata   // hue[7:0], saturation[15:8],
                                                 // lightness[23:16], red_chroma[32:24],
                                                 // green_chroma[41:33], zero[47:42]
);
    import rhc_pkg::*;

    logic              en;
    logic              f_valid;
    rhc_side_t         f_side;
    rhc_ops_t          f_ops;
    logic [QUO_W-1:0]  hue_q, sat_q, rc_q, gc_q;
    logic              vld_reg  [QUO_W];
    rhc_side_t         side_reg [QUO_W];
    logic [7:0]        hue_next;
    logic [OUT_W-1:0]  tdata_next;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    // The pipeline advances whenever the output register is free or drains.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    rhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .valid_reg (f_valid),
        .side_reg  (f_side),
        .ops_reg   (f_ops)
    );

    rhc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_hue (
        .aclk(aclk), .en(en), .num(f_ops.hue_num), .den(f_ops.hue_den), .quo(hue_q));
    rhc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_sat (
        .aclk(aclk), .en(en), .num(f_ops.sat_num), .den(f_ops.sat_den), .quo(sat_q));
    rhc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_rc (
        .aclk(aclk), .en(en), .num(f_ops.rc_num), .den(f_ops.tot_den), .quo(rc_q));
    rhc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_gc (
        .aclk(aclk), .en(en), .num(f_ops.gc_num), .den(f_ops.tot_den), .quo(gc_q));

    // Valid bits and pixel flags travel in step with the divider stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QUO_W; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= f_valid;
            for (int k = 1; k < QUO_W; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= f_side;
            for (int k = 1; k < QUO_W; k++) side_reg[k] <= side_reg[k-1];
        end
    end

    // Final assembly: sector offset, gray and black pixel overrides.
    always_comb begin
        if (side_reg[QUO_W-1].gray)
            hue_next = 8'd0;
        else if (side_reg[QUO_W-1].neg)
            hue_next = side_reg[QUO_W-1].base - hue_q[7:0];
        else
            hue_next = side_reg[QUO_W-1].base + hue_q[7:0];

        tdata_next          = '0;
        tdata_next[7:0]     = hue_next;
        tdata_next[15:8]    = side_reg[QUO_W-1].gray ? 8'd0 : sat_q[7:0];
        tdata_next[23:16]   = side_reg[QUO_W-1].lit;
        tdata_next[32:24]   = side_reg[QUO_W-1].black ? 9'd0 : rc_q;
        tdata_next[41:33]   = side_reg[QUO_W-1].black ? 9'd0 : gc_q;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[QUO_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== dv/rhc_checker.sv =====
// ----------------------------------------------------------------------------
// rhc_checker
// Watches both pixel channels, computes the expected HSL and chromaticity
// values for every accepted input beat and compares them with output beats.
// ----------------------------------------------------------------------------
module rhc_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [rhc_pkg::IN_W-1:0]   s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [rhc_pkg::OUT_W-1:0]  m_tdata,
    output int                         errors,
    output int                         pending,
    output int                         seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [8:0] gc;
        logic [8:0] rc;
        logic [7:0] lit;
        logic [7:0] sat;
        logic [7:0] hue;
    } hsl_t;

    hsl_t hsl_queue[$];

    // Offset by sector plus 40*(p-q)/d rounded toward minus infinity.
    function automatic int hue_part(int base, int p, int q, int d);
        if (p >= q)
            return base + (40 * (p - q)) / d;
        return base - (40 * (q - p) + d - 1) / d;
    endfunction

    function automatic hsl_t convert_pixel(logic [23:0] px);
        hsl_t o;
        int r, g, b, mx, mn, sm, d, tot;
        r = int'(px[7:0]);
        g = int'(px[15:8]);
        b = int'(px[23:16]);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sm = mx + mn;
        o = '0;
        o.lit = 8'((240 * sm) / 510);
        if (mx != mn) begin
            d = mx - mn;
            o.sat = 8'((sm < 255) ? (240 * d) / sm : (240 * d) / (510 - sm));
            // Ties on the maximum go to red, then green.
            if (r == mx)
                o.hue = 8'(hue_part((g >= b) ? 0 : 240, g, b, d));
            else if (g == mx)
                o.hue = 8'(hue_part(80, b, r, d));
            else
                o.hue = 8'(hue_part(160, r, g, d));
        end
        tot = r + g + b;
        if (tot != 0) begin
            o.rc = 9'((256 * r) / tot);
            o.gc = 9'((256 * g) / tot);
        end
        return o;
    endfunction

    assign pending = hsl_queue.size();

    initial begin
        errors = 0;
        seen = 0;
    end

    always @(posedge aclk) begin
        hsl_t want, got;
        if (aresetn && s_tvalid && s_tready)
            hsl_queue.push_back(convert_pixel(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[41:0];
            seen++;
            if (hsl_queue.size() == 0) begin
                $error("output beat with no pixel waiting: %h", m_tdata);
                errors++;
            end else begin
                want = hsl_queue.pop_front();
                if (got.hue !== want.hue) begin
                    $error("hue expected %0d actual %0d", want.hue, got.hue);
                    errors++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturation expected %0d actual %0d", want.sat, got.sat);
                    errors++;
                end
                if (got.lit !== want.lit) begin
                    $error("lightness expected %0d actual %0d", want.lit, got.lit);
                    errors++;
                end
                if (got.rc !== want.rc) begin
                    $error("red_chroma expected %0d actual %0d", want.rc, got.rc);
                    errors++;
                end
                if (got.gc !== want.gc) begin
                    $error("green_chroma expected %0d actual %0d", want.gc, got.gc);
                    errors++;
                end
                if (m_tdata[47:42] !== 6'd0) begin
                    $error("pad bits expected 0 actual %0h", m_tdata[47:42]);
                    errors++;
                end
            end
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random pixels in bursts with a stalling receiver and
// reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    int          errors, pending, seen, cycles, sent;

    rgb_to_hsl_and_chromaticity_core DUT (.*);
    rhc_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver stalls in runs: some stretches always ready, some choppy, some never ready.
    initial begin
        int mode, len;
        m_tready = 0;
        forever begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(1, 40);
            repeat (len) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready <= 1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= 0;
                endcase
            end
        end
    end

    // Offers one pixel and holds it until it is accepted.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        s_tvalid <= 1;
        s_tdata <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            s_tdata <= 24'($urandom);
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    logic [7:0] vals[8] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd127, 8'd128, 8'd85, 8'd170};

    initial begin
        int k, burst;
        logic [7:0] a, c;
        sent = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: black, white, grays, primaries, ties on the maximum,
        // lightness around the 255 boundary, negative hue wrap.
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(128, 128, 128);
        send_pixel(1, 1, 1);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(255, 255, 0);
        send_pixel(0, 255, 255);
        send_pixel(255, 0, 255);
        send_pixel(200, 200, 10);
        send_pixel(10, 200, 200);
        send_pixel(255, 0, 1);
        send_pixel(255, 1, 0);
        send_pixel(1, 0, 0);
        send_pixel(127, 127, 0);
        send_pixel(128, 127, 0);
        send_pixel(254, 1, 0);
        send_pixel(3, 0, 7);
        send_pixel(7, 3, 0);
        send_pixel(0, 7, 3);
        send_pixel(255, 254, 255);
        send_pixel(170, 85, 255);

        // Random pixels in bursts; some drawn from edge values or near-gray.
        while (sent < 1523) begin
            burst = $urandom_range(1, 30);
            for (k = 0; k < burst; k++) begin
                case ($urandom_range(0, 3))
                    0: send_pixel(vals[3'($urandom_range(0, 7))],
                                  vals[3'($urandom_range(0, 7))],
                                  vals[3'($urandom_range(0, 7))]);
                    1: begin
                        a = 8'($urandom);
                        c = 8'(a + $urandom_range(0, 2) - 1);
                        send_pixel(a, c, a);
                    end
                    default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            idle_gap();
        end
        s_tvalid <= 0;

        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        $display("Covered %0d pixels (%0d results) with bursty input and receiver stalls.",
                 sent, seen);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
